// File: rtl/dcf_pkg.sv
package dcf_pkg;

  localparam int DEF_TAPS    = 64;
  localparam int CMD_Q_DEPTH = 2;

  localparam logic [6:0] FACTOR_MIN = 7'd1;
  localparam logic [6:0] FACTOR_MAX = 7'd64;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MAC,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic        is_load;
    logic        fire;
    logic        keep;
    logic [15:0] re;
    logic [15:0] im;
  } cmd_t;

endpackage

// File: rtl/dcf_ram.sv
module dcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dcf_cmd_queue.sv
module dcf_cmd_queue
  import dcf_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/dcf_front.sv
module dcf_front
  import dcf_pkg::*;
#(
  parameter int TAPS = DEF_TAPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [6:0]              cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [15:0]             in_sample_re,
  input  logic [15:0]             in_sample_im,
  input  logic [5:0]              in_coef_index,
  input  logic [15:0]             in_coef_re,
  input  logic [15:0]             in_coef_im,
  input  logic                    back_ready,
  input  logic                    q_full,
  output logic                    q_push,
  output cmd_t                    q_cmd,
  output logic [$clog2(TAPS)-1:0] q_addr
);

  localparam int AW = $clog2(TAPS);

  logic [6:0]    factor_r;
  logic [5:0]    phase_r, phase_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [6:0]    factor_eff;
  logic [5:0]    phase_inc;
  logic          fire;

  assign in_stall = !back_ready || q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    if (factor_r < FACTOR_MIN) begin
      factor_eff = FACTOR_MIN;
    end else if (factor_r > FACTOR_MAX) begin
      factor_eff = FACTOR_MAX;
    end else begin
      factor_eff = factor_r;
    end
  end

  assign phase_inc = phase_r + 1'b1;
  assign fire      = (phase_inc == '0) || ({1'b0, phase_inc} >= factor_eff);

  always_comb begin
    phase_nxt = phase_r;
    wpos_nxt  = wpos_r;
    q_cmd     = '0;
    q_addr    = wpos_r;
    unique case (op_t'(in_opcode))
      OP_LOAD: begin
        q_cmd.is_load = 1'b1;
        q_cmd.keep    = (int'(in_coef_index) < TAPS);
        q_cmd.re      = in_coef_re;
        q_cmd.im      = in_coef_im;
        q_addr        = AW'(in_coef_index);
      end
      OP_SAMPLE: begin
        q_cmd.fire = fire;
        q_cmd.keep = 1'b1;
        q_cmd.re   = in_sample_re;
        q_cmd.im   = in_sample_im;
        if (q_push) begin
          phase_nxt = fire ? '0 : phase_inc;
          wpos_nxt  = (wpos_r == AW'(TAPS - 1)) ? '0 : wpos_r + 1'b1;
        end
      end
      default: begin
        q_cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_MIN;
      phase_r  <= '0;
      wpos_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        factor_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      wpos_r  <= wpos_nxt;
    end
  end

endmodule

// File: rtl/dcf_back.sv
module dcf_back
  import dcf_pkg::*;
#(
  parameter int TAPS = DEF_TAPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output logic                    ready,
  input  logic                    q_valid,
  input  cmd_t                    q_cmd,
  input  logic [$clog2(TAPS)-1:0] q_addr,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [15:0]             out_re,
  output logic [15:0]             out_im
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = 33 + $clog2(TAPS);
  localparam int TW    = ACC_W + 1;
  localparam int QN    = TW - 15;

  bk_state_t st_r, st_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] tap_r, tap_nxt;
  logic [AW-1:0] dly_r, dly_nxt;
  logic          iss_r, iss_nxt;
  logic          rd_v_r, rd_last_r;
  logic          prod_v_r, prod_last_r;

  logic signed [31:0] prr_r, pii_r, pri_r, pir_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_re_nxt;
  logic signed [ACC_W-1:0] acc_im_r, acc_im_nxt;
  logic signed [32:0] term_re, term_im;

  logic          dl_we, tp_we;
  logic [AW-1:0] dl_waddr, tp_waddr;
  logic [31:0]   dl_wdata, tp_wdata;
  logic [31:0]   dl_rdata, tp_rdata;
  logic signed [15:0] xr, xi, hr, hi;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_re_r, out_im_r;
  logic        out_load;

  function automatic logic [15:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [TW-1:0] t;
    logic signed [QN-1:0] q;
    t = TW'(a) + TW'(16384);
    q = $signed(t[TW-1:15]);
    if (q > QN'(32767)) begin
      q = QN'(32767);
    end else if (q < QN'(-32768)) begin
      q = QN'(-32768);
    end
    return q[15:0];
  endfunction

  dcf_ram #(.WIDTH(32), .DEPTH(TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dly_r),
    .rdata (dl_rdata)
  );

  dcf_ram #(.WIDTH(32), .DEPTH(TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tp_we),
    .waddr (tp_waddr),
    .wdata (tp_wdata),
    .raddr (tap_r),
    .rdata (tp_rdata)
  );

  assign ready = (st_r != BK_CLEAR);
  assign xr    = $signed(dl_rdata[31:16]);
  assign xi    = $signed(dl_rdata[15:0]);
  assign hr    = $signed(tp_rdata[31:16]);
  assign hi    = $signed(tp_rdata[15:0]);

  assign term_re = 33'(prr_r) - 33'(pii_r);
  assign term_im = 33'(pri_r) + 33'(pir_r);

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    tap_nxt       = tap_r;
    dly_nxt       = dly_r;
    iss_nxt       = iss_r;
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    dl_we         = 1'b0;
    tp_we         = 1'b0;
    dl_waddr      = q_addr;
    tp_waddr      = q_addr;
    dl_wdata      = {q_cmd.re, q_cmd.im};
    tp_wdata      = {q_cmd.re, q_cmd.im};
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    if (prod_v_r) begin
      acc_re_nxt = acc_re_r + ACC_W'(term_re);
      acc_im_nxt = acc_im_r + ACC_W'(term_im);
    end

    unique case (st_r)
      BK_CLEAR: begin
        dl_we    = 1'b1;
        tp_we    = 1'b1;
        dl_waddr = clr_r;
        tp_waddr = clr_r;
        dl_wdata = '0;
        tp_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == AW'(TAPS - 1)) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_load) begin
            tp_we = q_cmd.keep;
          end else begin
            dl_we = 1'b1;
            if (q_cmd.fire) begin
              st_nxt     = BK_MAC;
              tap_nxt    = '0;
              dly_nxt    = q_addr;
              iss_nxt    = 1'b1;
              acc_re_nxt = '0;
              acc_im_nxt = '0;
            end
          end
        end
      end
      BK_MAC: begin
        if (iss_r) begin
          tap_nxt = tap_r + 1'b1;
          dly_nxt = (dly_r == '0) ? AW'(TAPS - 1) : dly_r - 1'b1;
          if (tap_r == AW'(TAPS - 1)) begin
            iss_nxt = 1'b0;
          end
        end
        if (prod_v_r && prod_last_r) begin
          st_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_CLEAR;
      clr_r       <= '0;
      iss_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      rd_v_r      <= iss_r;
      rd_last_r   <= iss_r && (tap_r == AW'(TAPS - 1));
      prod_v_r    <= rd_v_r;
      prod_last_r <= rd_last_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_r    <= tap_nxt;
    dly_r    <= dly_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    prr_r    <= xr * hr;
    pii_r    <= xi * hi;
    pri_r    <= xr * hi;
    pir_r    <= xi * hr;
    if (out_load) begin
      out_re_r <= round_sat(acc_re_r);
      out_im_r <= round_sat(acc_im_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;

endmodule

// File: rtl/decimating_complex_fir.sv
// Complex decimating FIR, Q1.15 samples and taps. After reset the delay line
// and tap store are cleared, one entry per cycle; inputs stall until that
// is done. Items pass through a two-entry command queue to a single complex
// multiply-accumulate unit. A load, or a sample that does not complete a
// decimation period, is taken by the back end in its idle state. A sample
// that completes a period runs TAPS delay-line and tap reads through the
// shared MAC (RAM read register, product register, accumulator), then round
// and saturate into the output register when it is free. The queue accepts
// items meanwhile, but the back end takes the next only when idle again.
module decimating_complex_fir
  import dcf_pkg::*;
#(
  parameter int TAPS        = DEF_TAPS,
  parameter int QUEUE_DEPTH = CMD_Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_sample_re,
  input  logic [15:0] in_sample_im,
  input  logic [5:0]  in_coef_index,
  input  logic [15:0] in_coef_re,
  input  logic [15:0] in_coef_im,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_re,
  output logic [15:0] out_im
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $bits(cmd_t);
  localparam int QW = AW + CW;

  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic          q_push, q_full, q_pop, q_valid, back_ready;
  logic [QW-1:0] q_head;

  dcf_front #(.TAPS(TAPS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .in_coef_index (in_coef_index),
    .in_coef_re    (in_coef_re),
    .in_coef_im    (in_coef_im),
    .back_ready    (back_ready),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (f_cmd),
    .q_addr        (f_addr)
  );

  dcf_cmd_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({f_addr, f_cmd}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  dcf_back #(.TAPS(TAPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ready     (back_ready),
    .q_valid   (q_valid),
    .q_cmd     (cmd_t'(q_head[CW-1:0])),
    .q_addr    (q_head[QW-1:CW]),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_re    (out_re),
    .out_im    (out_im)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dcf_pkg::*;

  localparam int TAPS          = DEF_TAPS;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int CALM_PHASES   = 2;
  localparam int SETTLE_CYCLES = 2 * (TAPS + 4) + 16;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
  } cplx_t;

  class fir_scoreboard;
    logic signed [15:0] line_re [TAPS];
    logic signed [15:0] line_im [TAPS];
    logic signed [15:0] tap_re [TAPS];
    logic signed [15:0] tap_im [TAPS];
    int                 wr_pos;
    int                 phase;
    logic [6:0]         factor;
    cplx_t              decimated_q [$];
    int                 errors;

    function new();
      for (int i = 0; i < TAPS; i++) begin
        line_re[i] = '0;
        line_im[i] = '0;
        tap_re[i]  = '0;
        tap_im[i]  = '0;
      end
      wr_pos = 0;
      phase  = 0;
      factor = FACTOR_MIN;
      errors = 0;
    endfunction

    function void set_factor(logic [6:0] value);
      factor = value;
    endfunction

    function logic [15:0] round_q15(longint acc);
      longint q;
      q = (acc + 64'sd16384) >>> 15;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void absorb_item(op_t op, logic [15:0] sre, logic [15:0] sim,
                              logic [5:0] idx, logic [15:0] cre, logic [15:0] cim);
      int     eff;
      int     pos;
      longint acc_re;
      longint acc_im;
      longint xr, xi, hr, hi;
      cplx_t  res;
      if (op == OP_LOAD) begin
        if (int'(idx) < TAPS) begin
          tap_re[idx] = cre;
          tap_im[idx] = cim;
        end
        return;
      end
      line_re[wr_pos] = sre;
      line_im[wr_pos] = sim;
      eff = factor;
      if (eff < FACTOR_MIN) eff = FACTOR_MIN;
      if (eff > FACTOR_MAX) eff = FACTOR_MAX;
      phase = (phase + 1) % 64;
      if (phase != 0 && phase < eff) begin
        wr_pos = (wr_pos + 1) % TAPS;
        return;
      end
      phase  = 0;
      acc_re = 0;
      acc_im = 0;
      for (int i = 0; i < TAPS; i++) begin
        pos = (wr_pos + TAPS - i) % TAPS;
        xr = line_re[pos];
        xi = line_im[pos];
        hr = tap_re[i];
        hi = tap_im[i];
        acc_re += xr * hr - xi * hi;
        acc_im += xr * hi + xi * hr;
      end
      wr_pos = (wr_pos + 1) % TAPS;
      res.re = round_q15(acc_re);
      res.im = round_q15(acc_im);
      decimated_q.push_back(res);
    endfunction

    function void check_output(logic [15:0] re, logic [15:0] im);
      cplx_t exp_val;
      if (decimated_q.size() == 0) begin
        $display("%0t: unexpected output re=%0d im=%0d", $time, $signed(re), $signed(im));
        errors++;
        return;
      end
      exp_val = decimated_q.pop_front();
      if (re !== exp_val.re) begin
        $display("%0t: out_re mismatch expected %0d actual %0d",
                 $time, $signed(exp_val.re), $signed(re));
        errors++;
      end
      if (im !== exp_val.im) begin
        $display("%0t: out_im mismatch expected %0d actual %0d",
                 $time, $signed(exp_val.im), $signed(im));
        errors++;
      end
    endfunction

    function int pending();
      return decimated_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_SAMPLE;
  logic [15:0] in_sample_re = '0;
  logic [15:0] in_sample_im = '0;
  logic [5:0]  in_coef_index = '0;
  logic [15:0] in_coef_re = '0;
  logic [15:0] in_coef_im = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_re;
  logic [15:0] out_im;

  fir_scoreboard sb = new();

  int stall_pct = 0;
  int idle_pct = 0;
  int stall_left = 0;

  logic [6:0] factor_plan [PHASES] = '{7'd2, 7'd64, 7'd0, 7'd5, 7'd127, 7'd3,
                                       7'd1, 7'd16, 7'd7, 7'd1, 7'd33, 7'd1};

  decimating_complex_fir #(.TAPS(TAPS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .in_coef_index (in_coef_index),
    .in_coef_re    (in_coef_re),
    .in_coef_im    (in_coef_im),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_re        (out_re),
    .out_im        (out_im)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("decimating_complex_fir verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_output(out_re, out_im);
    end
  end

  function automatic logic [15:0] rand_q15();
    logic signed [15:0] v;
    int                 pick;
    v = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) v = 16'sh7fff;
    else if (pick == 1) v = 16'sh8000;
    else if (pick < 5) v = v >>> $urandom_range(1, 15);
    return v;
  endfunction

  task automatic write_factor(logic [6:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_factor(value);
  endtask

  task automatic send_item(op_t op, logic [15:0] sre, logic [15:0] sim,
                           logic [5:0] idx, logic [15:0] cre, logic [15:0] cim);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_sample_re  <= sre;
    in_sample_im  <= sim;
    in_coef_index <= idx;
    in_coef_re    <= cre;
    in_coef_im    <= cim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_item(op, sre, sim, idx, cre, cim);
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(OP_LOAD,   16'h8000, 16'h8000, 6'd0,  16'h7fff, 16'h0000);
    send_item(OP_SAMPLE, 16'h7fff, 16'h8000, 6'd63, 16'h7fff, 16'h8000);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 6'd21, 16'h8000, 16'h7fff);
    send_item(OP_LOAD,   16'h7fff, 16'h7fff, 6'd63, 16'h8000, 16'h8000);
    send_item(OP_LOAD,   16'h1234, 16'hedcb, 6'd0,  16'h8000, 16'h7fff);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 6'd5,  16'h5555, 16'haaaa);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 6'd0,  16'h0000, 16'h0000);
    send_item(OP_LOAD,   16'h0000, 16'h0000, 6'd0,  16'h4000, 16'h0000);
    send_item(OP_LOAD,   16'hffff, 16'hffff, 6'd63, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0001, 16'hffff, 6'd42, 16'hffff, 16'hffff);
    send_item(OP_SAMPLE, 16'hffff, 16'h0001, 6'd0,  16'h0000, 16'h0000);
    send_item(OP_LOAD,   16'h0000, 16'h0000, 6'd0,  16'h7fff, 16'h7fff);
    send_item(OP_SAMPLE, 16'h7fff, 16'h7fff, 6'd0,  16'h0000, 16'h0000);
    send_item(OP_LOAD,   16'h0000, 16'h0000, 6'd63, 16'h7fff, 16'h8000);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 6'd0,  16'h0000, 16'h0000);
    in_valid <= 1'b0;
    settle();
  endtask

  task automatic run_phase(logic [6:0] factor, bit calm);
    op_t op;
    int  pcts [3];
    pcts = '{0, 10, 35};
    write_factor(factor);
    idle_pct  = calm ? 0 : pcts[$urandom_range(0, 2)];
    stall_pct = calm ? 0 : pcts[$urandom_range(0, 2)];
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_SAMPLE;
      send_item(op, rand_q15(), rand_q15(), 6'($urandom), rand_q15(), rand_q15());
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        pause_input($urandom_range(1, 16));
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (TAPS + 8) @(posedge clk);
    write_factor(FACTOR_MIN);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      run_phase(factor_plan[p], p >= PHASES - CALM_PHASES);
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("decimating_complex_fir verification clean");
    end else begin
      $display("decimating_complex_fir verification failed");
    end
    $finish;
  end

endmodule
